// ----- hdl/jhs_pkg.sv -----
`default_nettype none

package jhs_pkg;

  // Field and port widths
  localparam int TEMP_W     = 16;
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Default largest grid width held by the line stores
  localparam int MAX_WIDTH_DEF = 256;

  // Result queue depth, a power of two of at least four
  localparam int OUT_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

  // Register reset values
  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 9'd256;

  // One emitted cell
  typedef struct packed {
    logic               frame_done;
    logic [COORD_W-1:0] cell_column;
    logic [COORD_W-1:0] cell_row;
    logic [TEMP_W-1:0]  new_temperature;
  } result_t;

  // Up to two results pushed into the result queue in one cycle
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } res_push_t;

endpackage

`default_nettype wire

// ----- hdl/jhs_line_ram.sv -----
`default_nettype none

module jhs_line_ram #(
  parameter int WIDTH = jhs_pkg::TEMP_W,
  parameter int DEPTH = jhs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/jhs_out_fifo.sv -----
`default_nettype none

module jhs_out_fifo #(
  parameter int DEPTH = jhs_pkg::OUT_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire jhs_pkg::res_push_t        push,
  output      logic [$clog2(DEPTH):0]    count,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      jhs_pkg::result_t          out_res
);

  localparam int PW = $clog2(DEPTH);

  jhs_pkg::result_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;
  logic [1:0]    n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = entry_r[rd_ptr_r];
  assign count     = count_r;
  assign n_push    = {1'b0, push.push_a} + {1'b0, push.push_b};

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(n_push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the first pushed result at the write pointer, the second behind it
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entry_r[wr_ptr_r] <= push.res_a;
      if (push.push_b) begin
        entry_r[wr_ptr_r + PW'(1)] <= push.res_b;
      end
    end else if (push.push_b) begin
      entry_r[wr_ptr_r] <= push.res_b;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/jacobi_heat_stencil_sweep_unit.sv -----
// Each result passes the stage 1 registers and then the result queue to out_tvalid.
// Throughput: one input per cycle while in_tready is high, bounded by one line-store
// read and write per cycle. On the last grid row each input makes two results, so the
// input is throttled to the output rate of one result per cycle by the four-entry queue.
// Reset: row and column counters clear, grid_width and grid_height return to 256;
// the line stores are not cleared.
`default_nettype none

module jacobi_heat_stencil_sweep_unit #(
  parameter int MAX_WIDTH = jhs_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write channel
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [jhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [jhs_pkg::DIM_W-1:0]          cfg_data,
  // Input stream
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [jhs_pkg::TEMP_W-1:0]         in_tdata,   // temperature
  // Result stream
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [jhs_pkg::OUT_DATA_W-1:0]     out_tdata,  // new_temperature,
                                                              // cell_row, cell_column
  output      logic                               out_tlast   // frame_done
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int TW    = jhs_pkg::TEMP_W;
  localparam int RW    = jhs_pkg::COORD_W;
  localparam int QW    = $clog2(jhs_pkg::OUT_DEPTH) + 1;

  logic [jhs_pkg::DIM_W-1:0] grid_width_r, grid_width_nxt;
  logic [jhs_pkg::DIM_W-1:0] grid_height_r, grid_height_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [CW-1:0]             width_last;
  logic [RW-1:0]             height_last;
  logic                      cfg_hit;
  logic                      in_accept;
  logic                      last_col, last_row;
  logic [CW-1:0]             mid_raddr;

  // Stage 1 registers
  logic            s1_valid_r;
  logic [TW-1:0]   s1_temp_r;
  logic [RW-1:0]   s1_row_r;
  logic [CW-1:0]   s1_col_r;
  logic            s1_above_r;
  logic            s1_last_row_r;
  logic            s1_last_col_r;
  logic            s1_border_r;

  logic [TW-1:0]   centre_r;
  logic [TW-1:0]   left_r;
  logic [TW-1:0]   upper_rdata;
  logic [TW-1:0]   mid_rdata;
  logic [TW+1:0]   sum;
  logic [TW-1:0]   new_val;
  logic [1:0]      pending;
  logic [QW:0]     occupancy;
  logic [QW-1:0]   q_count;

  jhs_pkg::res_push_t push;
  jhs_pkg::result_t   q_res;

  // Configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == jhs_pkg::REG_GRID_WIDTH) ||
                                   (cfg_index == jhs_pkg::REG_GRID_HEIGHT));

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_valid && (cfg_index == jhs_pkg::REG_GRID_WIDTH)) begin
      grid_width_nxt = cfg_data;
    end
    if (cfg_valid && (cfg_index == jhs_pkg::REG_GRID_HEIGHT)) begin
      grid_height_nxt = cfg_data;
    end
  end

  // Clamp the grid dimensions and keep the last index of each
  always_comb begin
    if (grid_width_r < 9'd3) begin
      width_last = CW'(2);
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      width_last = CW'(MAX_WIDTH - 1);
    end else begin
      width_last = CW'(grid_width_r - 9'd1);
    end
    if (grid_height_r < 9'd3) begin
      height_last = 8'd2;
    end else if (grid_height_r > 9'd256) begin
      height_last = 8'd255;
    end else begin
      height_last = 8'(grid_height_r - 9'd1);
    end
  end

  assign last_col  = (col_r == width_last);
  assign last_row  = (row_r == height_last);
  assign in_accept = in_tvalid && in_tready;

  // Raster position of the next input
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 8'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= jhs_pkg::GRID_WIDTH_RST;
      grid_height_r <= jhs_pkg::GRID_HEIGHT_RST;
      col_r         <= '0;
      row_r         <= '0;
      s1_valid_r    <= 1'b0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      s1_valid_r    <= in_accept;
    end
  end

  // Capture the accepted transaction for the compute stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_temp_r     <= in_tdata;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_above_r    <= (row_r != '0);
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
      s1_border_r   <= (row_r == 8'd1) || (col_r == '0) || last_col;
    end
  end

  // Prefetch the right neighbor; at the row end fetch column 0 for the next row
  assign mid_raddr = last_col ? '0 : col_r + CW'(1);

  // Row r-2 store: read on accept, rotated in from the middle row in stage 1
  jhs_line_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_WIDTH)
  ) u_upper_line (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_col_r),
    .wdata(centre_r),
    .re   (in_accept),
    .raddr(col_r),
    .rdata(upper_rdata)
  );

  // Row r-1 store: takes the new input on accept
  jhs_line_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_WIDTH)
  ) u_middle_line (
    .clk  (clk),
    .we   (in_accept),
    .waddr(col_r),
    .wdata(in_tdata),
    .re   (in_accept),
    .raddr(mid_raddr),
    .rdata(mid_rdata)
  );

  // Hold the centre of the next column and the left neighbor of this one
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      centre_r <= mid_rdata;
      left_r   <= centre_r;
    end
  end

  // Five-point update
  assign sum     = {2'b00, upper_rdata} + {2'b00, s1_temp_r} +
                   {2'b00, left_r} + {2'b00, mid_rdata};
  assign new_val = s1_border_r ? centre_r : sum[TW+1:2];

  always_comb begin
    push.push_a                = s1_valid_r && s1_above_r;
    push.push_b                = s1_valid_r && s1_last_row_r;
    push.res_a.new_temperature = new_val;
    push.res_a.cell_row        = s1_row_r - 8'd1;
    push.res_a.cell_column     = 8'(s1_col_r);
    push.res_a.frame_done      = 1'b0;
    push.res_b.new_temperature = s1_temp_r;
    push.res_b.cell_row        = s1_row_r;
    push.res_b.cell_column     = 8'(s1_col_r);
    push.res_b.frame_done      = s1_last_col_r;
  end

  jhs_out_fifo #(
    .DEPTH(jhs_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .count    (q_count),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (q_res)
  );

  // Accept only while the queue has room for two more results after stage 1
  assign pending   = {1'b0, push.push_a} + {1'b0, push.push_b};
  assign occupancy = {1'b0, q_count} + (QW+1)'(pending);
  assign in_tready = (occupancy <= (QW+1)'(jhs_pkg::OUT_DEPTH - 2));

  assign out_tdata = {q_res.cell_column, q_res.cell_row, q_res.new_temperature};
  assign out_tlast = q_res.frame_done;

  // Every accepted transaction reaches the compute stage in the next cycle
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transaction did not reach stage 1");

  // Stage 1 never runs without a transaction accepted in the cycle before
  a_stage_source: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(in_accept))
    else $error("stage 1 valid without an accepted transaction");

  // Ready leaves room in the queue for the worst case of two results
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (occupancy + (QW+1)'(2) <= (QW+1)'(jhs_pkg::OUT_DEPTH)))
    else $error("input ready while result queue could overflow");

  // The queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count <= QW'(jhs_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- sim/jacobi_heat_stencil_sweep_unit_tb.sv -----
module jacobi_heat_stencil_sweep_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W        = jhs_pkg::MAX_WIDTH_DEF;
  localparam int unsigned MAX_H        = 256;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          RAND_ITEMS   = 400;
  localparam longint      CYCLE_LIMIT  = 600000;

  // Writes to these indexes fall outside the register map
  localparam logic [jhs_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [jhs_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [jhs_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [jhs_pkg::DIM_W-1:0]       cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [jhs_pkg::TEMP_W-1:0]      in_tdata;    // temperature
  logic                            out_tvalid;
  logic                            out_tready;
  logic [jhs_pkg::OUT_DATA_W-1:0]  out_tdata;   // new_temperature, cell_row, cell_column
  logic                            out_tlast;   // frame_done

  logic rx_ready;
  logic long_hold;
  logic hold_req;
  logic tx_idle_en;
  logic rx_idle_en;

  // Sweep predictor state
  logic [jhs_pkg::DIM_W-1:0]  grid_w_reg;
  logic [jhs_pkg::DIM_W-1:0]  grid_h_reg;
  logic [jhs_pkg::TEMP_W-1:0] upper_row [MAX_W];
  logic [jhs_pkg::TEMP_W-1:0] middle_row [MAX_W];
  int unsigned                next_row;
  int unsigned                next_col;
  jhs_pkg::result_t           cells_due [$];

  int     fail_count = 0;
  int     items_sent;
  int     cells_checked = 0;
  int     sweeps_done = 0;
  int     cfg_writes;
  int     in_stalls = 0;
  longint cycles = 0;

  assign out_tready = rx_ready & ~long_hold;

  jacobi_heat_stencil_sweep_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog and stall bookkeeping
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_tvalid === 1'b1 && in_tready === 1'b0) begin
      in_stalls <= in_stalls + 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Clamp a dimension register to the range the block uses
  function automatic int unsigned fit_dim(input logic [jhs_pkg::DIM_W-1:0] v,
                                          input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_cells();
    return fit_dim(grid_w_reg, MAX_W) * fit_dim(grid_h_reg, MAX_H);
  endfunction

  // Rotate one column of the line stores and queue the cells this input completes
  function automatic void advance_sweep(input logic [jhs_pkg::TEMP_W-1:0] t);
    int unsigned                w;
    int unsigned                h;
    int unsigned                r;
    int unsigned                c;
    logic [jhs_pkg::TEMP_W-1:0] above;
    logic [jhs_pkg::TEMP_W-1:0] centre;
    logic [jhs_pkg::TEMP_W+1:0] sum;
    jhs_pkg::result_t           emitted;
    w = fit_dim(grid_w_reg, MAX_W);
    h = fit_dim(grid_h_reg, MAX_H);
    r = next_row;
    c = next_col;
    if (r >= h) r = h - 1;
    if (c >= w) c = w - 1;
    above = upper_row[c];
    centre = middle_row[c];
    upper_row[c] = centre;
    middle_row[c] = t;
    // Cell one row up: border passes through, interior averages four neighbors
    if (r >= 1) begin
      if (r == 1 || c == 0 || c == w - 1) begin
        emitted.new_temperature = centre;
      end else begin
        sum = {2'b00, above} + {2'b00, t} + {2'b00, upper_row[c-1]}
            + {2'b00, middle_row[c+1]};
        emitted.new_temperature = sum[jhs_pkg::TEMP_W+1:2];
      end
      emitted.cell_row = jhs_pkg::COORD_W'(r - 1);
      emitted.cell_column = jhs_pkg::COORD_W'(c);
      emitted.frame_done = 1'b0;
      cells_due.push_back(emitted);
    end
    // Bottom row is border too and goes out right away
    if (r == h - 1) begin
      emitted.new_temperature = t;
      emitted.cell_row = jhs_pkg::COORD_W'(r);
      emitted.cell_column = jhs_pkg::COORD_W'(c);
      emitted.frame_done = (c == w - 1);
      cells_due.push_back(emitted);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endfunction

  function automatic logic [jhs_pkg::TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF - 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one temperature and hold it until the block takes it
  task automatic send_temp(input logic [jhs_pkg::TEMP_W-1:0] t);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = t;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    advance_sweep(t);
    items_sent++;
  endtask

  task automatic send_cells(input int unsigned n);
    repeat (n) send_temp(pick_temp());
  endtask

  // Drop the input and let every pending result drain out
  task automatic settle_block();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jhs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [jhs_pkg::DIM_W-1:0] val);
    settle_block();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    cfg_writes++;
    // Known registers restart the sweep; unknown indexes change nothing
    if (idx == jhs_pkg::REG_GRID_WIDTH || idx == jhs_pkg::REG_GRID_HEIGHT) begin
      if (idx == jhs_pkg::REG_GRID_WIDTH) grid_w_reg = val;
      else grid_h_reg = val;
      next_row = 0;
      next_col = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset dimensions: a full first row of 256 plus two cells of the next
  task automatic test_reset_width();
    send_cells(MAX_W + 2);
  endtask

  // Saturated neighbors, a truncated average and the smallest grid
  task automatic test_corner_values();
    write_reg(jhs_pkg::REG_GRID_WIDTH, 9'd3);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'd3);
    repeat (9) send_temp(16'hFFFF);
    send_temp(16'h0000); send_temp(16'h0001); send_temp(16'h0000);
    send_temp(16'h0001); send_temp(16'hFFFF); send_temp(16'h0001);
    send_temp(16'h0000); send_temp(16'h0000); send_temp(16'h0000);
  endtask

  // Writes outside the register map leave a sweep in progress alone
  task automatic test_unused_index();
    send_cells(5);
    write_reg(REG_UNUSED_HI, 9'h000);
    write_reg(REG_UNUSED_LO, 9'h1FF);
    send_cells(4);
  endtask

  // A register write in mid-sweep starts over at the top-left cell
  task automatic test_restart();
    send_cells(4);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'd3);
    send_cells(9);
  endtask

  // Out-of-range dimensions clamp to the smallest and largest grids;
  // the widest grid only needs its first row and four cells past the wrap
  task automatic test_register_extremes();
    write_reg(jhs_pkg::REG_GRID_WIDTH, 9'd0);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'd0);
    send_cells(frame_cells());
    write_reg(jhs_pkg::REG_GRID_WIDTH, 9'h1FF);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'd2);
    send_cells(MAX_W + 4);
    write_reg(jhs_pkg::REG_GRID_WIDTH, 9'd1);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'h1FF);
    send_cells(frame_cells());
  endtask

  // Stop the result side for a long stretch while input keeps coming
  task automatic test_backpressure();
    write_reg(jhs_pkg::REG_GRID_WIDTH, 9'd8);
    write_reg(jhs_pkg::REG_GRID_HEIGHT, 9'd4);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = 1'b1;
    send_cells(frame_cells());
    settle_block();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Mostly whole sweeps of random size and content, some cut short
  task automatic test_random_sweeps();
    int                        start;
    int                        sel;
    int unsigned               left_n;
    int unsigned               n;
    bit                        must_cfg;
    logic [jhs_pkg::DIM_W-1:0] w_raw;
    logic [jhs_pkg::DIM_W-1:0] h_raw;
    start = items_sent;
    must_cfg = 1'b1;
    while (items_sent - start < RAND_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (must_cfg || $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 39);
        if (sel == 0) begin
          w_raw = jhs_pkg::DIM_W'($urandom_range(257, 511));
          h_raw = jhs_pkg::DIM_W'($urandom_range(0, 4));
        end else if (sel == 1) begin
          w_raw = jhs_pkg::DIM_W'($urandom_range(0, 4));
          h_raw = jhs_pkg::DIM_W'($urandom_range(257, 511));
        end else if (sel < 8) begin
          w_raw = jhs_pkg::DIM_W'($urandom_range(0, 40));
          h_raw = jhs_pkg::DIM_W'($urandom_range(0, 6));
        end else begin
          w_raw = jhs_pkg::DIM_W'($urandom_range(3, 12));
          h_raw = jhs_pkg::DIM_W'($urandom_range(3, 8));
        end
        write_reg(jhs_pkg::REG_GRID_WIDTH, w_raw);
        write_reg(jhs_pkg::REG_GRID_HEIGHT, h_raw);
        must_cfg = 1'b0;
      end
      left_n = unsigned'(RAND_ITEMS - (items_sent - start));
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, frame_cells() - 1);
        must_cfg = 1'b1;
      end else begin
        n = frame_cells();
        if ($urandom_range(0, 3) == 0) n = 2 * n;
      end
      // Trim the last batch to the item budget; a trimmed sweep restarts
      if (n > left_n) begin
        n = left_n;
        must_cfg = 1'b1;
      end
      send_cells(n);
    end
  endtask

  // Long receiver hold-off, timed on its own
  initial begin
    long_hold = 1'b0;
    wait (hold_req === 1'b1);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold = 1'b0;
  end

  // Result side: random ready gaps, compare each transaction with the oldest expectation
  initial begin : result_check
    int               gap;
    jhs_pkg::result_t want;
    rx_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        @(negedge clk);
        rx_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      rx_ready = 1'b1;
      do begin
        @(posedge clk);
      end while (out_tvalid !== 1'b1 || out_tready !== 1'b1);
      if (cells_due.size() == 0) begin
        $error("result with nothing expected: tdata=%h tlast=%b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = cells_due.pop_front();
        if (out_tdata[jhs_pkg::TEMP_W-1:0] !== want.new_temperature) begin
          $error("new_temperature: expected %0d, got %0d",
                 want.new_temperature, out_tdata[jhs_pkg::TEMP_W-1:0]);
          fail_count++;
        end
        if (out_tdata[jhs_pkg::TEMP_W+jhs_pkg::COORD_W-1:jhs_pkg::TEMP_W]
            !== want.cell_row) begin
          $error("cell_row: expected %0d, got %0d", want.cell_row,
                 out_tdata[jhs_pkg::TEMP_W+jhs_pkg::COORD_W-1:jhs_pkg::TEMP_W]);
          fail_count++;
        end
        if (out_tdata[jhs_pkg::TEMP_W+2*jhs_pkg::COORD_W-1:jhs_pkg::TEMP_W+jhs_pkg::COORD_W]
            !== want.cell_column) begin
          $error("cell_column: expected %0d, got %0d", want.cell_column,
                 out_tdata[jhs_pkg::TEMP_W+2*jhs_pkg::COORD_W-1:
                           jhs_pkg::TEMP_W+jhs_pkg::COORD_W]);
          fail_count++;
        end
        if (out_tlast !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, out_tlast);
          fail_count++;
        end
      end
      cells_checked++;
      if (out_tlast === 1'b1) sweeps_done++;
    end
  end

  // Main sequence
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    grid_w_reg = jhs_pkg::GRID_WIDTH_RST;
    grid_h_reg = jhs_pkg::GRID_HEIGHT_RST;
    next_row = 0;
    next_col = 0;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_width();
    test_corner_values();
    test_unused_index();
    test_restart();
    test_register_extremes();
    test_backpressure();
    test_random_sweeps();
    settle_block();

    $display("Sent %0d temperatures and checked %0d cells over %0d finished sweeps.",
             items_sent, cells_checked, sweeps_done);
    $display("Made %0d register writes; the input stalled for %0d cycles in %0d cycles.",
             cfg_writes, in_stalls, cycles);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
